FILE: hdl/sha256_block_hash_top_macros.svh
// ----------------------------------------------------------------------------
// SHA-256 block hash: assertion macros
// Clocked checks on clk, held off while rst is high. Empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef SHA256_BLOCK_HASH_TOP_MACROS_SVH
`define SHA256_BLOCK_HASH_TOP_MACROS_SVH

`ifndef SYNTH

// property that must hold in the same cycle
`define SHABH_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("shabh check failed");

// consequence that must hold in the cycle after the antecedent
`define SHABH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("shabh sequence check failed");

`else

`define SHABH_ASSERT(lbl, prop)
`define SHABH_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: hdl/shabh_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 block hash: shared package
// Widths, queue item type, round constants and the SHA-256 mixing functions.
// ----------------------------------------------------------------------------
package shabh_pkg;

  localparam int WORD_W      = 32;
  localparam int BLOCK_WORDS = 16;
  localparam int SLOT_W      = 4;
  localparam int ROUND_W     = 6;
  localparam int NUM_INIT    = 8;
  localparam int DIG_IDX_W   = 3;
  localparam int CFG_IDX_W   = 4;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [SLOT_W-1:0]    LAST_SLOT  = SLOT_W'(BLOCK_WORDS - 1);
  localparam logic [ROUND_W-1:0]   LAST_ROUND = '1;
  localparam logic [DIG_IDX_W-1:0] LAST_DIG   = DIG_IDX_W'(NUM_INIT - 1);

  // one classified message word on its way from front to back
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [SLOT_W-1:0] slot;
    logic              load_init;
    logic              close_block;
    logic              emit;
  } item_t;

  function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x,
                                             input int n);
    rotr = (x >> n) | (x << (WORD_W - n));
  endfunction

  function automatic logic [WORD_W-1:0] big_sigma0(input logic [WORD_W-1:0] x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [WORD_W-1:0] big_sigma1(input logic [WORD_W-1:0] x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [WORD_W-1:0] small_sigma0(input logic [WORD_W-1:0] x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [WORD_W-1:0] small_sigma1(input logic [WORD_W-1:0] x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  // standard SHA-256 initial chaining values
  function automatic logic [WORD_W-1:0] init_value(input logic [DIG_IDX_W-1:0] i);
    case (i)
      3'd0: init_value = 32'h6a09e667;
      3'd1: init_value = 32'hbb67ae85;
      3'd2: init_value = 32'h3c6ef372;
      3'd3: init_value = 32'ha54ff53a;
      3'd4: init_value = 32'h510e527f;
      3'd5: init_value = 32'h9b05688c;
      3'd6: init_value = 32'h1f83d9ab;
      3'd7: init_value = 32'h5be0cd19;
      default: init_value = '0;
    endcase
  endfunction

  // round constants
  function automatic logic [WORD_W-1:0] round_k(input logic [ROUND_W-1:0] t);
    case (t)
      6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
      6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
      6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
      6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
      6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
      6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
      6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
      6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
      6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
      6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
      6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
      6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
      6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
      6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
      6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
      6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
      6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
      6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
      6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
      6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
      6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
      6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
      6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
      6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
      6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
      6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
      6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
      6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
      6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
      6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
      6'd62: round_k = 32'hbef9a3f7;  6'd63: round_k = 32'hc67178f2;
      default: round_k = '0;
    endcase
  endfunction

endpackage

FILE: hdl/shabh_if.sv
// ----------------------------------------------------------------------------
// SHA-256 block hash: channel interfaces
// Valid/ready channels for message words, digest words and register writes.
// ----------------------------------------------------------------------------

// message word channel
interface shabh_in_if;
  logic                            valid;
  logic                            ready;
  logic [shabh_pkg::WORD_W-1:0]    message_word;
  logic                            start_message;
  logic                            end_message;

  modport source (output valid, message_word, start_message, end_message,
                  input ready);
  modport sink   (input valid, message_word, start_message, end_message,
                  output ready);
endinterface

// digest word channel
interface shabh_out_if;
  logic                            valid;
  logic                            ready;
  logic [shabh_pkg::WORD_W-1:0]    digest_word;
  logic [shabh_pkg::DIG_IDX_W-1:0] digest_index;
  logic                            last_word;

  modport source (output valid, digest_word, digest_index, last_word,
                  input ready);
  modport sink   (input valid, digest_word, digest_index, last_word,
                  output ready);
endinterface

// register write channel
interface shabh_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [shabh_pkg::CFG_IDX_W-1:0] index;
  logic [shabh_pkg::WORD_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/shabh_front.sv
// ----------------------------------------------------------------------------
// SHA-256 block hash: front end
// Accepts message words, tracks the slot within the block and tags each item.
// ----------------------------------------------------------------------------
module shabh_front (
  input  logic                clk,
  input  logic                rst,
  shabh_in_if.sink            in_ch,
  input  logic                q_full,
  output logic                q_push,
  output shabh_pkg::item_t    q_item
);

  logic [shabh_pkg::SLOT_W-1:0] word_count;
  logic [shabh_pkg::SLOT_W-1:0] slot;
  logic                         close_block;

  // start of message restarts the block at slot zero
  always_comb begin
    slot        = in_ch.start_message ? '0 : word_count;
    close_block = (slot == shabh_pkg::LAST_SLOT);
  end

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  always_comb begin
    q_item.word        = in_ch.message_word;
    q_item.slot        = slot;
    q_item.load_init   = in_ch.start_message;
    q_item.close_block = close_block;
    q_item.emit        = in_ch.end_message && close_block;
  end

  // word position within the current block
  always_ff @(posedge clk) begin
    if (rst) begin
      word_count <= '0;
    end else if (q_push) begin
      word_count <= close_block ? '0 : slot + 1'b1;
    end
  end

endmodule

FILE: hdl/shabh_queue.sv
// ----------------------------------------------------------------------------
// SHA-256 block hash: item queue
// Short first-word-fall-through queue between front end and compression back.
// ----------------------------------------------------------------------------
`include "sha256_block_hash_top_macros.svh"

module shabh_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  shabh_pkg::item_t    push_item,
  output logic                full,
  input  logic                pop,
  output shabh_pkg::item_t    pop_item,
  output logic                empty
);

  shabh_pkg::item_t                entries [shabh_pkg::QDEPTH];
  logic [shabh_pkg::QPTR_W-1:0]    wr_ptr;
  logic [shabh_pkg::QPTR_W-1:0]    rd_ptr;
  logic [shabh_pkg::QCNT_W-1:0]    count;

  assign full     = (count == shabh_pkg::QCNT_W'(shabh_pkg::QDEPTH));
  assign empty    = (count == '0);
  assign pop_item = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + shabh_pkg::QCNT_W'(push) - shabh_pkg::QCNT_W'(pop);
    end
  end

  `SHABH_ASSERT(a_q_no_overflow, !(full && push))
  `SHABH_ASSERT(a_q_no_underflow, !(empty && pop))
  `SHABH_ASSERT(a_q_ptr_match, (empty || full) |-> (wr_ptr == rd_ptr))

endmodule

FILE: hdl/shabh_back.sv
// ----------------------------------------------------------------------------
// SHA-256 block hash: compression back end
// Holds init and chaining words, runs 64 rounds per block, emits the digest.
// ----------------------------------------------------------------------------
`include "sha256_block_hash_top_macros.svh"

module shabh_back (
  input  logic                clk,
  input  logic                rst,
  shabh_cfg_if.sink           cfg_ch,
  shabh_out_if.source         out_ch,
  input  logic                q_empty,
  input  shabh_pkg::item_t    q_item,
  output logic                q_pop
);

  typedef enum logic [3:0] {
    ST_LOAD  = 4'b0001,
    ST_ROUND = 4'b0010,
    ST_FINAL = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t                                state;
  logic [shabh_pkg::ROUND_W-1:0]         round_count;
  logic                                  emit_pending;
  logic [shabh_pkg::DIG_IDX_W-1:0]       emit_idx;
  logic [shabh_pkg::WORD_W-1:0]          init_h        [shabh_pkg::NUM_INIT];
  logic [shabh_pkg::WORD_W-1:0]          chaining_hash [shabh_pkg::NUM_INIT];
  logic [shabh_pkg::WORD_W-1:0]          working_vars  [shabh_pkg::NUM_INIT];
  logic [shabh_pkg::WORD_W-1:0]          sched         [shabh_pkg::BLOCK_WORDS];
  logic                                  out_valid;
  logic [shabh_pkg::WORD_W-1:0]          out_word;
  logic [shabh_pkg::DIG_IDX_W-1:0]       out_idx;
  logic                                  out_last;

  logic                                  load_out;
  logic                                  cfg_hit;
  logic [shabh_pkg::WORD_W-1:0]          t1;
  logic [shabh_pkg::WORD_W-1:0]          t2;
  logic [shabh_pkg::WORD_W-1:0]          w_new;

  assign cfg_ch.ready = 1'b1;
  assign cfg_hit      = cfg_ch.valid &&
                        (cfg_ch.index < shabh_pkg::CFG_IDX_W'(shabh_pkg::NUM_INIT));

  assign q_pop    = (state == ST_LOAD) && !q_empty;
  assign load_out = (state == ST_EMIT) && (!out_valid || out_ch.ready);

  assign out_ch.valid        = out_valid;
  assign out_ch.digest_word  = out_word;
  assign out_ch.digest_index = out_idx;
  assign out_ch.last_word    = out_last;

  // one round: a..h live in working_vars[0..7], schedule word at sched[0]
  always_comb begin
    t1 = working_vars[7] + shabh_pkg::big_sigma1(working_vars[4])
       + ((working_vars[4] & working_vars[5]) ^ (~working_vars[4] & working_vars[6]))
       + shabh_pkg::round_k(round_count) + sched[0];
    t2 = shabh_pkg::big_sigma0(working_vars[0])
       + ((working_vars[0] & working_vars[1]) ^ (working_vars[0] & working_vars[2])
          ^ (working_vars[1] & working_vars[2]));
    w_new = sched[0] + shabh_pkg::small_sigma0(sched[1]) + sched[9]
          + shabh_pkg::small_sigma1(sched[14]);
  end

  // init registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < shabh_pkg::NUM_INIT; i++) begin
        init_h[i] <= shabh_pkg::init_value(shabh_pkg::DIG_IDX_W'(i));
      end
    end else if (cfg_hit) begin
      init_h[cfg_ch.index[shabh_pkg::DIG_IDX_W-1:0]] <= cfg_ch.data;
    end
  end

  // sequencer and chaining words
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_LOAD;
      round_count  <= '0;
      emit_pending <= 1'b0;
      emit_idx     <= '0;
      for (int i = 0; i < shabh_pkg::NUM_INIT; i++) begin
        chaining_hash[i] <= shabh_pkg::init_value(shabh_pkg::DIG_IDX_W'(i));
      end
    end else begin
      case (state)
        ST_LOAD: begin
          if (q_pop) begin
            if (q_item.load_init) begin
              chaining_hash <= init_h;
            end
            if (q_item.close_block) begin
              round_count  <= '0;
              emit_pending <= q_item.emit;
              state        <= ST_ROUND;
            end
          end
        end
        ST_ROUND: begin
          round_count <= round_count + 1'b1;
          if (round_count == shabh_pkg::LAST_ROUND) begin
            state <= ST_FINAL;
          end
        end
        ST_FINAL: begin
          for (int i = 0; i < shabh_pkg::NUM_INIT; i++) begin
            chaining_hash[i] <= chaining_hash[i] + working_vars[i];
          end
          emit_idx <= '0;
          state    <= emit_pending ? ST_EMIT : ST_LOAD;
        end
        ST_EMIT: begin
          if (load_out) begin
            emit_idx <= emit_idx + 1'b1;
            if (emit_idx == shabh_pkg::LAST_DIG) begin
              state <= ST_LOAD;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  // schedule window and working variables
  always_ff @(posedge clk) begin
    if (q_pop) begin
      sched[q_item.slot] <= q_item.word;
      if (q_item.close_block) begin
        working_vars <= chaining_hash;
      end
    end else if (state == ST_ROUND) begin
      for (int i = 0; i < shabh_pkg::BLOCK_WORDS - 1; i++) begin
        sched[i] <= sched[i + 1];
      end
      sched[shabh_pkg::BLOCK_WORDS - 1] <= w_new;
      working_vars[7] <= working_vars[6];
      working_vars[6] <= working_vars[5];
      working_vars[5] <= working_vars[4];
      working_vars[4] <= working_vars[3] + t1;
      working_vars[3] <= working_vars[2];
      working_vars[2] <= working_vars[1];
      working_vars[1] <= working_vars[0];
      working_vars[0] <= t1 + t2;
    end
  end

  // digest output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_word <= chaining_hash[emit_idx];
      out_idx  <= emit_idx;
      out_last <= (emit_idx == shabh_pkg::LAST_DIG);
    end
  end

  `SHABH_ASSERT_NEXT(a_rounds_to_fold, (state == ST_ROUND) && (round_count == shabh_pkg::LAST_ROUND), state == ST_FINAL)
  `SHABH_ASSERT_NEXT(a_last_digest_frees, load_out && (emit_idx == shabh_pkg::LAST_DIG), state == ST_LOAD)
  `SHABH_ASSERT(a_last_flag_index, out_valid |-> (out_last == (out_idx == shabh_pkg::LAST_DIG)))

endmodule

FILE: hdl/sha256_block_hash_top.sv
// ----------------------------------------------------------------------------
// SHA-256 block hash: top level
// Usage:
//   in_ch   padded message, one big-endian 32-bit word per item; sixteen words
//           make a block. start_message on the first word reloads the chaining
//           words from init_h0..init_h7; end_message on a block's sixteenth
//           word makes that block the last one of the message.
//   out_ch  after the last block, eight digest items, index 0 first, the
//           eighth flagged with last_word.
//   cfg_ch  writes init_h0..init_h7 at index 0..7; other indexes are ignored.
//           Write only while the block is idle; always ready.
// Throughput: in load, the back end takes one word a cycle from the queue while
//   it is not empty, then runs 64 rounds in one shared round unit and a fold
//   step, taking no new word until back in load. The round unit limits the rate.
// Output: once the last word of a message leaves the queue and its rounds and
//   fold are done, one digest item a cycle while the receiver takes them.
// Reset: init registers and chaining words return to the standard values,
//   the queue empties and the word count restarts.
// Stall: the output register holds its item; the four-entry queue keeps
//   taking words until full, then in_ch.ready drops.
// ----------------------------------------------------------------------------
module sha256_block_hash_top (
  input  logic          clk,
  input  logic          rst,
  shabh_in_if.sink      in_ch,
  shabh_out_if.source   out_ch,
  shabh_cfg_if.sink     cfg_ch
);

  logic                q_full;
  logic                q_empty;
  logic                q_push;
  logic                q_pop;
  shabh_pkg::item_t    push_item;
  shabh_pkg::item_t    pop_item;

  // word intake and classification
  shabh_front u_front (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (push_item)
  );

  // decoupling queue
  shabh_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .empty     (q_empty)
  );

  // compression and digest output
  shabh_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg_ch  (cfg_ch),
    .out_ch  (out_ch),
    .q_empty (q_empty),
    .q_item  (pop_item),
    .q_pop   (q_pop)
  );

endmodule
